FILE: sv/sexpr_tokenizer_top_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SEXPR_TOKENIZER_TOP_DEFINES_SVH
`define SEXPR_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SXT_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SXT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sxt_pkg.sv
// Shared types and constants for the S-expression tokenizer.
// No dependencies; used by the front, back and top-level tokenizer modules.
package sxt_pkg;

  // Default counter widths
  localparam int LINE_BITS_DEF   = 20;
  localparam int COLUMN_BITS_DEF = 16;

  // Queue depths
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int ERR_W   = 2;
  localparam int CLASS_W = 3;

  // Characters
  localparam logic [BYTE_W-1:0] CH_END    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h28;
  localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h29;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h27;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_QUOTE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STRING = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ATOM   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd5;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_END_IN_STR = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NL_IN_STR  = 2'd2;

  // Byte classes produced by the front end
  typedef enum logic [CLASS_W-1:0] {
    CL_END    = 3'd0,
    CL_NL     = 3'd1,
    CL_BLANK  = 3'd2,
    CL_OPEN   = 3'd3,
    CL_CLOSE  = 3'd4,
    CL_QUOTE  = 3'd5,
    CL_DQUOTE = 3'd6,
    CL_OTHER  = 3'd7
  } class_t;

endpackage

FILE: sv/sexpr_tokenizer_top.sv
// S-expression tokenizer, top level: front classifier, queue, back scanner, result queue.
// Depends on sxt_pkg, sxt_front, sxt_fifo and sxt_back.
//
// Usage:
//   Input channel: drive in_text_byte and raise in_push; the byte transfers at an
//   edge where in_full is low. A zero byte ends the text.
//   Result channel: while out_empty is low the oldest token byte sits on the out_
//   ports; it transfers at an edge where out_pop is high.
//   Each token byte is held until the next byte shows how it ends, so a byte's
//   result is caused by the byte after it (or by end of text, which always gives
//   exactly one result with out_text_done set).
//   A result caused by a byte passes the middle queue and the result queue before it
//   is visible. One byte per cycle, set by the back scanner, while the result queue has room.
//   A four-entry queue sits between classifier and scanner and a two-entry queue
//   on the result side; when the receiver stalls they fill and in_full rises.
//   Reset (rst_n low, synchronous) empties both queues and returns line and column
//   to 1 with nothing held.
module sexpr_tokenizer_top #(
  parameter int LINE_BITS   = sxt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = sxt_pkg::COLUMN_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic [sxt_pkg::BYTE_W-1:0] in_text_byte,
  output logic                       in_full,
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic [sxt_pkg::BYTE_W-1:0] out_byte,
  output logic [sxt_pkg::KIND_W-1:0] out_token_kind,
  output logic                       out_token_first,
  output logic                       out_token_last,
  output logic [LINE_BITS-1:0]       out_line_number,
  output logic [COLUMN_BITS-1:0]     out_column_number,
  output logic [sxt_pkg::ERR_W-1:0]  out_error_code,
  output logic                       out_text_done
);

  localparam int MID_W = sxt_pkg::BYTE_W + sxt_pkg::CLASS_W;
  localparam int OUT_W = sxt_pkg::BYTE_W + sxt_pkg::KIND_W + 2 + LINE_BITS + COLUMN_BITS
                         + sxt_pkg::ERR_W + 1;

  logic                        f_push, f_full;
  logic [sxt_pkg::BYTE_W-1:0]  f_byte;
  sxt_pkg::class_t             f_class;
  logic [MID_W-1:0]            mid_rdata;
  logic                        mid_empty, mid_pop;

  logic                        o_full, o_push;
  logic [sxt_pkg::BYTE_W-1:0]  o_byte;
  logic [sxt_pkg::KIND_W-1:0]  o_kind;
  logic                        o_first, o_last, o_done;
  logic [LINE_BITS-1:0]        o_line;
  logic [COLUMN_BITS-1:0]      o_column;
  logic [sxt_pkg::ERR_W-1:0]   o_err;
  logic [OUT_W-1:0]            o_wdata, o_rdata;

  // Classify incoming bytes
  sxt_front u_front (
    .in_push      (in_push),
    .in_text_byte (in_text_byte),
    .in_full      (in_full),
    .q_push       (f_push),
    .q_byte       (f_byte),
    .q_class      (f_class),
    .q_full       (f_full)
  );

  // Decouple classifier from scanner
  sxt_fifo #(
    .WIDTH (MID_W),
    .DEPTH (sxt_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_byte, f_class}),
    .full  (f_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  // Scan and emit token bytes
  sxt_back #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (mid_empty),
    .q_byte   (mid_rdata[MID_W-1:sxt_pkg::CLASS_W]),
    .q_class  (sxt_pkg::class_t'(mid_rdata[sxt_pkg::CLASS_W-1:0])),
    .q_pop    (mid_pop),
    .o_full   (o_full),
    .o_push   (o_push),
    .o_byte   (o_byte),
    .o_kind   (o_kind),
    .o_first  (o_first),
    .o_last   (o_last),
    .o_line   (o_line),
    .o_column (o_column),
    .o_err    (o_err),
    .o_done   (o_done)
  );

  assign o_wdata = {o_byte, o_kind, o_first, o_last, o_line, o_column, o_err, o_done};

  // Hold results until the receiver takes them
  sxt_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (sxt_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata (o_wdata),
    .full  (o_full),
    .pop   (out_pop),
    .rdata (o_rdata),
    .empty (out_empty)
  );

  assign {out_byte, out_token_kind, out_token_first, out_token_last, out_line_number,
          out_column_number, out_error_code, out_text_done} = o_rdata;

endmodule

FILE: sv/sxt_fifo.sv
// Small synchronous queue with registered storage and occupancy count.
// Standalone; used between front and back and on the result side.
module sxt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign rdata = mem_r[rptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Store incoming transfer
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: sv/sxt_front.sv
// Front end: accepts text bytes and tags each with its character class.
// Depends on sxt_pkg.
module sxt_front (
  input  logic                                in_push,
  input  logic [sxt_pkg::BYTE_W-1:0]          in_text_byte,
  output logic                                in_full,
  output logic                                q_push,
  output logic [sxt_pkg::BYTE_W-1:0]          q_byte,
  output sxt_pkg::class_t                     q_class,
  input  logic                                q_full
);

  // Pass backpressure straight to the producer
  assign in_full = q_full;
  assign q_push  = in_push;
  assign q_byte  = in_text_byte;

  // Classify the byte
  always_comb begin
    case (in_text_byte)
      sxt_pkg::CH_END:    q_class = sxt_pkg::CL_END;
      sxt_pkg::CH_NL:     q_class = sxt_pkg::CL_NL;
      sxt_pkg::CH_SPACE,
      sxt_pkg::CH_TAB:    q_class = sxt_pkg::CL_BLANK;
      sxt_pkg::CH_OPEN:   q_class = sxt_pkg::CL_OPEN;
      sxt_pkg::CH_CLOSE:  q_class = sxt_pkg::CL_CLOSE;
      sxt_pkg::CH_QUOTE:  q_class = sxt_pkg::CL_QUOTE;
      sxt_pkg::CH_DQUOTE: q_class = sxt_pkg::CL_DQUOTE;
      default:            q_class = sxt_pkg::CL_OTHER;
    endcase
  end

endmodule

FILE: sv/sxt_back.sv
// Back end: scan state machine, one-byte hold stage and line/column counters.
// Depends on sxt_pkg and sexpr_tokenizer_top_defines.svh.
`include "sexpr_tokenizer_top_defines.svh"

module sxt_back #(
  parameter int LINE_BITS   = sxt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = sxt_pkg::COLUMN_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // classified byte queue
  input  logic                         q_empty,
  input  logic [sxt_pkg::BYTE_W-1:0]   q_byte,
  input  sxt_pkg::class_t              q_class,
  output logic                         q_pop,
  // result queue
  input  logic                         o_full,
  output logic                         o_push,
  output logic [sxt_pkg::BYTE_W-1:0]   o_byte,
  output logic [sxt_pkg::KIND_W-1:0]   o_kind,
  output logic                         o_first,
  output logic                         o_last,
  output logic [LINE_BITS-1:0]         o_line,
  output logic [COLUMN_BITS-1:0]       o_column,
  output logic [sxt_pkg::ERR_W-1:0]    o_err,
  output logic                         o_done
);

  typedef enum logic [3:0] {
    MODE_BETWEEN = 4'b0001,
    MODE_ATOM    = 4'b0010,
    MODE_STRING  = 4'b0100,
    MODE_ERROR   = 4'b1000
  } mode_t;

  mode_t                       mode_r, mode_nxt;
  logic                        held_valid_r, held_valid_nxt;
  logic [sxt_pkg::BYTE_W-1:0]  held_byte_r, held_byte_nxt;
  logic [sxt_pkg::KIND_W-1:0]  held_kind_r, held_kind_nxt;
  logic                        held_first_r, held_first_nxt;
  logic [LINE_BITS-1:0]        held_line_r, held_line_nxt;
  logic [COLUMN_BITS-1:0]      held_col_r, held_col_nxt;
  logic [LINE_BITS-1:0]        line_r, line_nxt;
  logic [COLUMN_BITS-1:0]      col_r, col_nxt;

  logic                        fire;
  logic                        emit, last;
  logic [sxt_pkg::ERR_W-1:0]   err;
  logic                        done;
  logic                        do_between, do_hold, hold_first;
  logic [sxt_pkg::KIND_W-1:0]  hold_kind;
  logic [COLUMN_BITS-1:0]      col_inc;
  logic [LINE_BITS-1:0]        line_inc;

  assign fire  = !q_empty && !o_full;
  assign q_pop = fire;

  // Saturating increments
  assign col_inc  = (col_r == '1) ? col_r : col_r + COLUMN_BITS'(1);
  assign line_inc = (line_r == '1) ? line_r : line_r + LINE_BITS'(1);

  // Decide the transfer out and the next scan state
  always_comb begin
    emit           = 1'b0;
    last           = 1'b0;
    err            = sxt_pkg::ERR_NONE;
    done           = 1'b0;
    do_between     = 1'b0;
    do_hold        = 1'b0;
    hold_kind      = sxt_pkg::KIND_ATOM;
    hold_first     = 1'b0;
    mode_nxt       = mode_r;
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    held_kind_nxt  = held_kind_r;
    held_first_nxt = held_first_r;
    held_line_nxt  = held_line_r;
    held_col_nxt   = held_col_r;
    line_nxt       = line_r;
    col_nxt        = col_r;

    if (q_class == sxt_pkg::CL_END) begin
      // flush and return to reset state
      emit           = 1'b1;
      last           = 1'b1;
      err            = (mode_r == MODE_STRING) ? sxt_pkg::ERR_END_IN_STR : sxt_pkg::ERR_NONE;
      done           = 1'b1;
      mode_nxt       = MODE_BETWEEN;
      held_valid_nxt = 1'b0;
      held_byte_nxt  = '0;
      held_kind_nxt  = sxt_pkg::KIND_NONE;
      held_first_nxt = 1'b0;
      held_line_nxt  = LINE_BITS'(1);
      held_col_nxt   = COLUMN_BITS'(1);
      line_nxt       = LINE_BITS'(1);
      col_nxt        = COLUMN_BITS'(1);
    end else begin
      unique case (mode_r)
        MODE_BETWEEN: begin
          emit       = held_valid_r;
          last       = 1'b1;
          do_between = 1'b1;
        end
        MODE_ATOM: begin
          if (q_class == sxt_pkg::CL_BLANK || q_class == sxt_pkg::CL_NL ||
              q_class == sxt_pkg::CL_OPEN || q_class == sxt_pkg::CL_CLOSE) begin
            emit       = held_valid_r;
            last       = 1'b1;
            do_between = 1'b1;
          end else begin
            emit      = held_valid_r;
            do_hold   = 1'b1;
            hold_kind = sxt_pkg::KIND_ATOM;
          end
        end
        MODE_STRING: begin
          if (q_class == sxt_pkg::CL_NL) begin
            // newline in string: close token with error, drop till end
            emit           = 1'b1;
            last           = 1'b1;
            err            = sxt_pkg::ERR_NL_IN_STR;
            held_valid_nxt = 1'b0;
            mode_nxt       = MODE_ERROR;
          end else begin
            emit      = held_valid_r;
            do_hold   = 1'b1;
            hold_kind = sxt_pkg::KIND_STRING;
            if (q_class == sxt_pkg::CL_DQUOTE) begin
              mode_nxt = MODE_BETWEEN;
            end
          end
        end
        MODE_ERROR: begin
          // drop
        end
        default: begin
          mode_nxt = MODE_BETWEEN;
        end
      endcase

      if (do_between) begin
        held_valid_nxt = 1'b0;
        mode_nxt       = MODE_BETWEEN;
        hold_first     = 1'b1;
        case (q_class)
          sxt_pkg::CL_NL: begin
            line_nxt = line_inc;
            col_nxt  = COLUMN_BITS'(1);
          end
          sxt_pkg::CL_BLANK: col_nxt = col_inc;
          sxt_pkg::CL_OPEN: begin
            do_hold   = 1'b1;
            hold_kind = sxt_pkg::KIND_OPEN;
          end
          sxt_pkg::CL_CLOSE: begin
            do_hold   = 1'b1;
            hold_kind = sxt_pkg::KIND_CLOSE;
          end
          sxt_pkg::CL_QUOTE: begin
            do_hold   = 1'b1;
            hold_kind = sxt_pkg::KIND_QUOTE;
          end
          sxt_pkg::CL_DQUOTE: begin
            do_hold   = 1'b1;
            hold_kind = sxt_pkg::KIND_STRING;
            mode_nxt  = MODE_STRING;
          end
          sxt_pkg::CL_OTHER: begin
            do_hold   = 1'b1;
            hold_kind = sxt_pkg::KIND_ATOM;
            mode_nxt  = MODE_ATOM;
          end
          default: begin
          end
        endcase
      end

      // capture byte with its position
      if (do_hold) begin
        held_valid_nxt = 1'b1;
        held_byte_nxt  = q_byte;
        held_kind_nxt  = hold_kind;
        held_first_nxt = hold_first;
        held_line_nxt  = line_r;
        held_col_nxt   = col_r;
        col_nxt        = col_inc;
      end
    end
  end

  // Drive the result transfer from the held byte or the counters
  assign o_push   = fire && emit;
  assign o_byte   = held_valid_r ? held_byte_r : '0;
  assign o_kind   = held_valid_r ? held_kind_r : sxt_pkg::KIND_NONE;
  assign o_first  = held_valid_r && held_first_r;
  assign o_last   = held_valid_r && last;
  assign o_line   = held_valid_r ? held_line_r : line_r;
  assign o_column = held_valid_r ? held_col_r : col_r;
  assign o_err    = err;
  assign o_done   = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_BETWEEN;
      held_valid_r <= 1'b0;
      held_byte_r  <= '0;
      held_kind_r  <= sxt_pkg::KIND_NONE;
      held_first_r <= 1'b0;
      held_line_r  <= LINE_BITS'(1);
      held_col_r   <= COLUMN_BITS'(1);
      line_r       <= LINE_BITS'(1);
      col_r        <= COLUMN_BITS'(1);
    end else if (fire) begin
      mode_r       <= mode_nxt;
      held_valid_r <= held_valid_nxt;
      held_byte_r  <= held_byte_nxt;
      held_kind_r  <= held_kind_nxt;
      held_first_r <= held_first_nxt;
      held_line_r  <= held_line_nxt;
      held_col_r   <= held_col_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
    end
  end

  `SXT_ASSERT_NOW(a_str_held, clk, rst_n, mode_r == MODE_STRING, held_valid_r,
    "string mode without a held byte")
  `SXT_ASSERT_NOW(a_err_quiet, clk, rst_n, mode_r == MODE_ERROR && o_push, o_done,
    "result produced while dropping after an error")
  `SXT_ASSERT_NEXT(a_end_reset, clk, rst_n, fire && q_class == sxt_pkg::CL_END,
    mode_r == MODE_BETWEEN && !held_valid_r && line_r == LINE_BITS'(1) &&
    col_r == COLUMN_BITS'(1), "state not restored after end of text")
  `SXT_ASSERT_NOW(a_no_over, clk, rst_n, o_push, !o_full,
    "result pushed into a full queue")

endmodule

FILE: verif/tb_sexpr_tokenizer_top.sv
// Self-checking testbench for the S-expression tokenizer top level.
// Depends on sxt_pkg and sexpr_tokenizer_top; a scanner model predicts results not in the table.
`timescale 1ns / 1ps

module tb_sexpr_tokenizer_top;

  localparam int LINE_W      = sxt_pkg::LINE_BITS_DEF;
  localparam int COL_W       = sxt_pkg::COLUMN_BITS_DEF;
  localparam int RAND_ITEMS  = 1420;
  localparam int IDLE_PCT    = 13;
  localparam int HOLD_CYCLES = 120;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 16;

  typedef enum logic [3:0] {
    SCAN_GAP    = 4'b0001,
    SCAN_ATOM   = 4'b0010,
    SCAN_STRING = 4'b0100,
    SCAN_DROP   = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic [sxt_pkg::BYTE_W-1:0] ch;
    logic [sxt_pkg::KIND_W-1:0] kind;
    logic                       first;
    logic                       last;
    logic [LINE_W-1:0]          line;
    logic [COL_W-1:0]           col;
    logic [sxt_pkg::ERR_W-1:0]  err;
    logic                       done;
  } tok_t;

  typedef struct packed {
    logic [sxt_pkg::BYTE_W-1:0] text;
    logic                       typed;
    tok_t                       want;
  } stim_t;

  localparam tok_t NO_TOK = '0;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_push = 1'b0;
  logic [sxt_pkg::BYTE_W-1:0] in_text_byte = '0;
  logic                       in_full;
  logic                       out_pop = 1'b0;
  logic                       out_empty;
  logic [sxt_pkg::BYTE_W-1:0] out_byte;
  logic [sxt_pkg::KIND_W-1:0] out_token_kind;
  logic                       out_token_first;
  logic                       out_token_last;
  logic [LINE_W-1:0]          out_line_number;
  logic [COL_W-1:0]           out_column_number;
  logic [sxt_pkg::ERR_W-1:0]  out_error_code;
  logic                       out_text_done;

  sexpr_tokenizer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_text_byte      (in_text_byte),
    .in_full           (in_full),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_byte          (out_byte),
    .out_token_kind    (out_token_kind),
    .out_token_first   (out_token_first),
    .out_token_last    (out_token_last),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number),
    .out_error_code    (out_error_code),
    .out_text_done     (out_text_done)
  );

  // Directed table: extremes, every token kind, both string errors, drop mode
  stim_t directed_rows [27] = '{
    '{sxt_pkg::CH_END,    1'b1, '{sxt_pkg::CH_END, sxt_pkg::KIND_NONE, 1'b0, 1'b0,
                                  LINE_W'(1), COL_W'(1), sxt_pkg::ERR_NONE, 1'b1}},
    '{sxt_pkg::CH_OPEN,   1'b0, NO_TOK},
    '{sxt_pkg::CH_CLOSE,  1'b1, '{sxt_pkg::CH_OPEN, sxt_pkg::KIND_OPEN, 1'b1, 1'b1,
                                  LINE_W'(1), COL_W'(1), sxt_pkg::ERR_NONE, 1'b0}},
    '{sxt_pkg::CH_QUOTE,  1'b1, '{sxt_pkg::CH_CLOSE, sxt_pkg::KIND_CLOSE, 1'b1, 1'b1,
                                  LINE_W'(1), COL_W'(2), sxt_pkg::ERR_NONE, 1'b0}},
    '{8'h61,              1'b1, '{sxt_pkg::CH_QUOTE, sxt_pkg::KIND_QUOTE, 1'b1, 1'b1,
                                  LINE_W'(1), COL_W'(3), sxt_pkg::ERR_NONE, 1'b0}},
    '{8'hFF,              1'b0, NO_TOK},
    '{sxt_pkg::CH_DQUOTE, 1'b0, NO_TOK},
    '{sxt_pkg::CH_QUOTE,  1'b0, NO_TOK},
    '{sxt_pkg::CH_NL,     1'b0, NO_TOK},
    '{sxt_pkg::CH_DQUOTE, 1'b0, NO_TOK},
    '{8'h80,              1'b0, NO_TOK},
    '{sxt_pkg::CH_DQUOTE, 1'b0, NO_TOK},
    '{sxt_pkg::CH_SPACE,  1'b0, NO_TOK},
    '{sxt_pkg::CH_TAB,    1'b0, NO_TOK},
    '{8'h01,              1'b0, NO_TOK},
    '{sxt_pkg::CH_END,    1'b0, NO_TOK},
    '{sxt_pkg::CH_DQUOTE, 1'b0, NO_TOK},
    '{8'h78,              1'b0, NO_TOK},
    '{sxt_pkg::CH_END,    1'b1, '{8'h78, sxt_pkg::KIND_STRING, 1'b0, 1'b1,
                                  LINE_W'(1), COL_W'(2), sxt_pkg::ERR_END_IN_STR, 1'b1}},
    '{sxt_pkg::CH_DQUOTE, 1'b0, NO_TOK},
    '{sxt_pkg::CH_NL,     1'b1, '{sxt_pkg::CH_DQUOTE, sxt_pkg::KIND_STRING, 1'b1, 1'b1,
                                  LINE_W'(1), COL_W'(1), sxt_pkg::ERR_NL_IN_STR, 1'b0}},
    '{8'h7F,              1'b0, NO_TOK},
    '{sxt_pkg::CH_NL,     1'b0, NO_TOK},
    '{sxt_pkg::CH_END,    1'b1, '{sxt_pkg::CH_END, sxt_pkg::KIND_NONE, 1'b0, 1'b0,
                                  LINE_W'(1), COL_W'(2), sxt_pkg::ERR_NONE, 1'b1}},
    '{8'h7E,              1'b0, NO_TOK},
    '{sxt_pkg::CH_OPEN,   1'b0, NO_TOK},
    '{sxt_pkg::CH_END,    1'b0, NO_TOK}
  };

  stim_t text_queue[$];
  tok_t  pending_tokens[$];
  tok_t  want_tok;
  tok_t  scan_tok;
  bit    scan_got;

  // Scanner model state
  scan_mode_t                 mode;
  logic                       held_ok;
  logic [sxt_pkg::BYTE_W-1:0] held_ch;
  logic [sxt_pkg::KIND_W-1:0] held_kind;
  logic                       held_first;
  logic [LINE_W-1:0]          held_line;
  logic [COL_W-1:0]           held_col;
  logic [LINE_W-1:0]          line_cnt;
  logic [COL_W-1:0]           col_cnt;

  int unsigned n_in, n_out, n_texts, n_errors_seen, full_cycles, mismatches, stall_cycles;
  int unsigned rand_base;
  logic        hold_off = 1'b0;

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void reset_scan();
    mode       = SCAN_GAP;
    held_ok    = 1'b0;
    held_ch    = '0;
    held_kind  = sxt_pkg::KIND_NONE;
    held_first = 1'b0;
    held_line  = LINE_W'(1);
    held_col   = COL_W'(1);
    line_cnt   = LINE_W'(1);
    col_cnt    = COL_W'(1);
  endfunction

  function automatic bit is_delim(logic [sxt_pkg::BYTE_W-1:0] c);
    return c == sxt_pkg::CH_SPACE || c == sxt_pkg::CH_TAB || c == sxt_pkg::CH_NL ||
           c == sxt_pkg::CH_OPEN || c == sxt_pkg::CH_CLOSE;
  endfunction

  function automatic void bump_col();
    if (col_cnt != '1) col_cnt++;
  endfunction

  // Build the token byte for the held character, or a bare item if nothing is held
  function automatic tok_t held_token(logic last, logic [sxt_pkg::ERR_W-1:0] err, logic done);
    tok_t t;
    if (held_ok) begin
      t = '{held_ch, held_kind, held_first, last, held_line, held_col, err, done};
    end else begin
      t = '{sxt_pkg::CH_END, sxt_pkg::KIND_NONE, 1'b0, 1'b0, line_cnt, col_cnt, err, done};
    end
    return t;
  endfunction

  function automatic void hold_char(logic [sxt_pkg::BYTE_W-1:0] c,
                                    logic [sxt_pkg::KIND_W-1:0] kind, logic first);
    held_ok    = 1'b1;
    held_ch    = c;
    held_kind  = kind;
    held_first = first;
    held_line  = line_cnt;
    held_col   = col_cnt;
    bump_col();
  endfunction

  // Handle a byte outside any token; the previous held byte has already gone out
  function automatic void start_token(logic [sxt_pkg::BYTE_W-1:0] c);
    held_ok = 1'b0;
    mode    = SCAN_GAP;
    if (c == sxt_pkg::CH_NL) begin
      if (line_cnt != '1) line_cnt++;
      col_cnt = COL_W'(1);
    end else if (c == sxt_pkg::CH_SPACE || c == sxt_pkg::CH_TAB) begin
      bump_col();
    end else if (c == sxt_pkg::CH_OPEN) begin
      hold_char(c, sxt_pkg::KIND_OPEN, 1'b1);
    end else if (c == sxt_pkg::CH_CLOSE) begin
      hold_char(c, sxt_pkg::KIND_CLOSE, 1'b1);
    end else if (c == sxt_pkg::CH_QUOTE) begin
      hold_char(c, sxt_pkg::KIND_QUOTE, 1'b1);
    end else if (c == sxt_pkg::CH_DQUOTE) begin
      hold_char(c, sxt_pkg::KIND_STRING, 1'b1);
      mode = SCAN_STRING;
    end else begin
      hold_char(c, sxt_pkg::KIND_ATOM, 1'b1);
      mode = SCAN_ATOM;
    end
  endfunction

  // Advance the scanner by one text byte; got is set when a token byte comes out
  function automatic void scan_byte(logic [sxt_pkg::BYTE_W-1:0] c, output bit got,
                                    output tok_t t);
    got = 1'b0;
    t   = '0;
    if (c == sxt_pkg::CH_END) begin
      t   = held_token(1'b1, mode == SCAN_STRING ? sxt_pkg::ERR_END_IN_STR : sxt_pkg::ERR_NONE,
                       1'b1);
      got = 1'b1;
      reset_scan();
    end else begin
      case (mode)
        SCAN_GAP: begin
          if (held_ok) begin
            t   = held_token(1'b1, sxt_pkg::ERR_NONE, 1'b0);
            got = 1'b1;
          end
          start_token(c);
        end
        SCAN_ATOM: begin
          if (held_ok) begin
            t   = held_token(is_delim(c), sxt_pkg::ERR_NONE, 1'b0);
            got = 1'b1;
          end
          if (is_delim(c)) start_token(c);
          else hold_char(c, sxt_pkg::KIND_ATOM, 1'b0);
        end
        SCAN_STRING: begin
          if (c == sxt_pkg::CH_NL) begin
            t       = held_token(1'b1, sxt_pkg::ERR_NL_IN_STR, 1'b0);
            got     = 1'b1;
            held_ok = 1'b0;
            mode    = SCAN_DROP;
          end else begin
            if (held_ok) begin
              t   = held_token(1'b0, sxt_pkg::ERR_NONE, 1'b0);
              got = 1'b1;
            end
            hold_char(c, sxt_pkg::KIND_STRING, 1'b0);
            if (c == sxt_pkg::CH_DQUOTE) mode = SCAN_GAP;
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void add_byte(logic [sxt_pkg::BYTE_W-1:0] c);
    text_queue.push_back('{c, 1'b0, NO_TOK});
  endfunction

  function automatic logic [sxt_pkg::BYTE_W-1:0] atom_char();
    logic [sxt_pkg::BYTE_W-1:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_delim(c));
    return c;
  endfunction

  function automatic logic [sxt_pkg::BYTE_W-1:0] string_char();
    logic [sxt_pkg::BYTE_W-1:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == sxt_pkg::CH_NL || c == sxt_pkg::CH_DQUOTE);
    return c;
  endfunction

  function automatic logic [sxt_pkg::BYTE_W-1:0] blank_char();
    case ($urandom_range(3))
      0:       return sxt_pkg::CH_TAB;
      1:       return sxt_pkg::CH_NL;
      default: return sxt_pkg::CH_SPACE;
    endcase
  endfunction

  // One random text: mostly well-formed tokens, some broken strings, some raw noise
  function automatic void gen_text();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(9))
          0: add_byte(sxt_pkg::CH_OPEN);
          1: add_byte(sxt_pkg::CH_CLOSE);
          2: add_byte(sxt_pkg::CH_QUOTE);
          3, 4: begin
            add_byte(sxt_pkg::CH_DQUOTE);
            repeat ($urandom_range(0, 6)) add_byte(string_char());
            add_byte(sxt_pkg::CH_DQUOTE);
          end
          5, 6, 7: repeat ($urandom_range(1, 6)) add_byte(atom_char());
          default: ;
        endcase
        if ($urandom_range(2) != 0) add_byte(blank_char());
      end
      // Leave a string open, sometimes broken by a newline and trailing junk
      if (pick == 1) begin
        add_byte(sxt_pkg::CH_DQUOTE);
        add_byte(string_char());
        if ($urandom_range(1) != 0) begin
          add_byte(sxt_pkg::CH_NL);
          repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(1, 255)));
        end
      end
    end
    add_byte(sxt_pkg::CH_END);
  endfunction

  function automatic bit idle_now();
    bit quiet;
    quiet = n_in >= rand_base + 300 && n_in < rand_base + 700;
    return !quiet && $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic void match(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ERROR %s expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  // Sender: predict on each transfer, then offer the next byte unless idling
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_full) full_cycles++;
      if (in_push && !in_full) begin
        n_in++;
        scan_byte(text_queue[0].text, scan_got, scan_tok);
        if (scan_got) pending_tokens.push_back(text_queue[0].typed ? text_queue[0].want : scan_tok);
        if (text_queue[0].text == sxt_pkg::CH_END) n_texts++;
        text_queue.pop_front();
      end
      if (text_queue.size() != 0 && !idle_now()) begin
        in_push      <= 1'b1;
        in_text_byte <= text_queue[0].text;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Receiver: check each transfer against the oldest expected token byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        n_out++;
        if (pending_tokens.size() == 0) begin
          mismatches++;
          $display("%0t ERROR expected no result actual byte %0h kind %0d", $time, out_byte,
                   out_token_kind);
        end else begin
          want_tok = pending_tokens.pop_front();
          if (want_tok.err != sxt_pkg::ERR_NONE) n_errors_seen++;
          match("byte",   32'(want_tok.ch),    32'(out_byte));
          match("kind",   32'(want_tok.kind),  32'(out_token_kind));
          match("first",  32'(want_tok.first), 32'(out_token_first));
          match("last",   32'(want_tok.last),  32'(out_token_last));
          match("line",   32'(want_tok.line),  32'(out_line_number));
          match("column", 32'(want_tok.col),   32'(out_column_number));
          match("error",  32'(want_tok.err),   32'(out_error_code));
          match("done",   32'(want_tok.done),  32'(out_text_done));
        end
      end
      out_pop <= !hold_off && !idle_now();
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t ERROR no transfer for %0d cycles", $time, STALL_LIMIT);
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Back-pressure: stall the receiver for a long stretch while bytes keep coming
  initial begin
    wait (rand_base != 0 && n_in >= rand_base + 900);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    reset_scan();
    foreach (directed_rows[i]) text_queue.push_back(directed_rows[i]);
    rand_base = text_queue.size();
    while (text_queue.size() < rand_base + RAND_ITEMS) gen_text();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all bytes sent, all token bytes back, then a quiet wait
    while (text_queue.size() != 0 || pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d bytes in %0d texts, checked %0d token bytes (%0d with errors).",
             n_in, n_texts, n_out, n_errors_seen);
    $display("Input stalled by full for %0d cycles; %0d mismatches.", full_cycles, mismatches);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
